// ===== sv/pfa_pkg.sv =====
// Shared types and codes for the page-frame allocator.
// Used by the datapath unit, the top level and the checkers.
`default_nettype none

package pfa_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } pfa_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_BADFREE = 2'd2
  } pfa_status_e;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } pfa_alu_op_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STEP1  = 5'b00010,
    ST_STEP2  = 5'b00100,
    ST_STEP3  = 5'b01000,
    ST_FINISH = 5'b10000
  } pfa_state_e;

  typedef struct packed {
    pfa_alu_op_e        op;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
  } pfa_alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;  // carry out on add, no-borrow on subtract
    logic              lt;     // a < b, valid on subtract
  } pfa_alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/pfa_alu.sv =====
// Shared 32-bit add/subtract unit; serves every compare and the bump advance.
// Depends on pfa_pkg for the request and response structs.
`default_nettype none

module pfa_alu (
  input  pfa_pkg::pfa_alu_req_t req_i,
  output pfa_pkg::pfa_alu_rsp_t rsp_o
);
  import pfa_pkg::*;

  logic [DATA_W-1:0] b_eff;
  logic [DATA_W:0]   total;
  logic              is_sub;

  assign is_sub = (req_i.op == ALU_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;
  assign total  = {1'b0, req_i.a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, is_sub};

  assign rsp_o.sum   = total[DATA_W-1:0];
  assign rsp_o.carry = total[DATA_W];
  // a borrow shows up as a missing carry out of the subtract
  assign rsp_o.lt    = is_sub & ~total[DATA_W];

endmodule

`default_nettype wire

// ===== sv/pfa_link_mem.sv =====
// Free-list link store: one entry per page, holding a valid bit and the next page.
// Single write port and one registered read port; no reset.
`default_nettype none

module pfa_link_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned DATA_W = 13
) (
  input  wire                      clk_i,
  input  wire                      wr_en_i,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire  [DATA_W-1:0]        wr_data_i,
  input  wire                      rd_en_i,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/page_frame_allocator.sv =====
// Page-frame allocator: LIFO free list with bump-pointer fallback.
// Allocates go through STEP1 and STEP2, or STEP1 alone when out of memory; frees
// go through STEP1 to STEP3. All end in FINISH, which waits for the output
// register; the next request is taken only back in IDLE. One shared add/subtract
// unit and the link store read port set these steps. Reset clears the list,
// registers and bump pointer at once; the link store needs no clearing.
`default_nettype none

module page_frame_allocator #(
  parameter int unsigned PAGE_SIZE = 4096,  // power of two
  parameter int unsigned MAX_PAGES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] free_address
  input  wire         s_axis_tuser,   // [0] mode
  // result channel
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] page_address
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfa_pkg::*;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int unsigned PN_W       = $clog2(MAX_PAGES);
  localparam int unsigned LINK_W     = PN_W + 1;

  pfa_state_e        state_q, state_d;
  pfa_mode_e         mode_q, mode_d;
  logic [31:0]       addr_q, addr_d;
  logic              bad_q, bad_d;
  logic [31:0]       base_q, base_d;
  logic [31:0]       limit_q, limit_d;
  logic [31:0]       bump_q, bump_d;
  logic [PN_W-1:0]   head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [31:0]       res_addr_q, res_addr_d;
  pfa_status_e       res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_addr_q, out_addr_d;
  pfa_status_e       out_status_q, out_status_d;

  pfa_alu_req_t      alu_req;
  pfa_alu_rsp_t      alu_rsp;

  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [LINK_W-1:0] mem_rd_data;
  logic [31:0]       page_num;
  logic              cfg_wr;

  assign page_num = addr_q >> PAGE_SHIFT;
  assign cfg_wr   = psel & penable & pwrite & pready;

  pfa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  pfa_link_mem #(
    .DEPTH  (MAX_PAGES),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (page_num[PN_W-1:0]),
    .wr_data_i ({head_valid_q, head_q}),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (head_q),
    .rd_data_o (mem_rd_data)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    addr_d       = addr_q;
    bad_d        = bad_q;
    base_d       = base_q;
    limit_d      = limit_q;
    bump_d       = bump_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    alu_req      = '{op: ALU_SUB, a: addr_q, b: base_q};
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = pfa_mode_e'(s_axis_tuser);
          addr_d  = s_axis_tdata;
          bad_d   = 1'b0;
          state_d = ST_STEP1;
        end
      end
      ST_STEP1: begin
        if (mode_q == MODE_ALLOC) begin
          if (head_valid_q) begin
            mem_rd_en = 1'b1;
            state_d   = ST_STEP2;
          end else begin
            alu_req = '{op: ALU_SUB, a: bump_q, b: limit_q};
            if (alu_rsp.lt) begin
              res_addr_d   = bump_q;
              res_status_d = STATUS_OK;
              state_d      = ST_STEP2;
            end else begin
              res_addr_d   = '0;
              res_status_d = STATUS_OOM;
              state_d      = ST_FINISH;
            end
          end
        end else begin
          // below the reserved base, or not page aligned
          alu_req = '{op: ALU_SUB, a: addr_q, b: base_q};
          bad_d   = alu_rsp.lt | (addr_q[PAGE_SHIFT-1:0] != '0);
          state_d = ST_STEP2;
        end
      end
      ST_STEP2: begin
        if (mode_q == MODE_ALLOC) begin
          if (head_valid_q) begin
            // pop: link entry names the next head
            head_valid_d = mem_rd_data[PN_W];
            head_d       = mem_rd_data[PN_W-1:0];
            res_addr_d   = 32'(head_q) << PAGE_SHIFT;
            res_status_d = STATUS_OK;
          end else begin
            alu_req = '{op: ALU_ADD, a: bump_q, b: 32'(PAGE_SIZE)};
            bump_d  = alu_rsp.carry ? '1 : alu_rsp.sum;
          end
          state_d = ST_FINISH;
        end else begin
          alu_req = '{op: ALU_SUB, a: addr_q, b: limit_q};
          bad_d   = bad_q | ~alu_rsp.lt;
          state_d = ST_STEP3;
        end
      end
      ST_STEP3: begin
        // page must fit in the link store
        alu_req    = '{op: ALU_SUB, a: page_num, b: 32'(MAX_PAGES)};
        res_addr_d = '0;
        if (bad_q || !alu_rsp.lt) begin
          res_status_d = STATUS_BADFREE;
        end else begin
          mem_wr_en    = 1'b1;
          head_d       = page_num[PN_W-1:0];
          head_valid_d = 1'b1;
          res_status_d = STATUS_OK;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register frees up
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      if (paddr[2]) begin
        limit_d = pwdata;
      end else begin
        base_d = pwdata;
        bump_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      limit_q      <= '0;
      bump_q       <= '0;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      limit_q      <= limit_d;
      bump_q       <= bump_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    addr_q       <= addr_d;
    bad_q        <= bad_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? limit_q : base_q;

endmodule

`default_nettype wire

// ===== sv/pfa_checker.sv =====
// Port-level checks for the page-frame allocator, bound to the top level.
// Depends on pfa_pkg for the status codes.
`default_nettype none

module pfa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);
  import pfa_pkg::*;

  // status is never the unused code
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_OOM ||
                       m_axis_tuser == STATUS_BADFREE))
    else $error("illegal status code");

  // an error result carries a zero address
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero address");

  // a transaction in closes the request side for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

`default_nettype wire

// ===== tb/sv/page_frame_allocator_checker.sv =====
// Checker for the page-frame allocator: snoops the request, result and register
// channels, predicts each result and compares it. Depends on pfa_pkg.
`default_nettype none

module page_frame_allocator_checker #(
  parameter int unsigned PAGE_SIZE  = 4096,
  parameter int unsigned MAX_PAGES  = 4096,
  parameter logic [2:0]  BASE_ADDR  = 3'd0,
  parameter logic [2:0]  LIMIT_ADDR = 3'd4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_data_i,    // [31:0] free_address
  input  logic        req_user_i,    // [0] mode
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [31:0] rsp_data_i,    // [31:0] page_address
  input  logic [1:0]  rsp_user_i,    // [1:0] status
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int PN_W       = 32 - PAGE_SHIFT;

  typedef struct packed {
    logic [31:0] page_address;
    pfa_status_e status;
  } grant_t;

  typedef struct packed {
    logic            valid;
    logic [PN_W-1:0] next;
  } link_t;

  logic [31:0]     base_q;
  logic [31:0]     limit_q;
  logic [31:0]     bump_q;
  logic [PN_W-1:0] head_q;
  logic            head_valid_q;
  link_t           link_mem [MAX_PAGES];
  grant_t          grants_q [$];
  int              fails;
  int              checks;

  function automatic grant_t serve_request(pfa_mode_e mode, logic [31:0] addr);
    grant_t          g;
    link_t           link;
    logic [PN_W-1:0] pn;
    logic [32:0]     next_top;
    g.page_address = '0;
    g.status       = STATUS_OK;
    if (mode == MODE_ALLOC) begin
      if (head_valid_q) begin
        g.page_address = 32'(head_q) << PAGE_SHIFT;
        link           = link_mem[head_q];
        head_valid_q   = link.valid;
        head_q         = link.next;
      end else if (bump_q < limit_q) begin
        g.page_address = bump_q;
        next_top       = {1'b0, bump_q} + 33'(PAGE_SIZE);
        // saturate at the top of the address space
        bump_q         = next_top[32] ? '1 : next_top[31:0];
      end else begin
        g.status = STATUS_OOM;
      end
    end else begin
      pn = addr[31:PAGE_SHIFT];
      if (addr[PAGE_SHIFT-1:0] != '0 || addr < base_q || addr >= limit_q ||
          32'(pn) >= MAX_PAGES) begin
        g.status = STATUS_BADFREE;
      end else begin
        link_mem[pn] = '{valid: head_valid_q, next: head_q};
        head_q       = pn;
        head_valid_q = 1'b1;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      base_q       = '0;
      limit_q      = '0;
      bump_q       = '0;
      head_q       = '0;
      head_valid_q = 1'b0;
      fails        = 0;
      checks       = 0;
      grants_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == BASE_ADDR) begin
          base_q = pwdata_i;
          bump_q = pwdata_i;
        end else if (paddr_i == LIMIT_ADDR) begin
          limit_q = pwdata_i;
        end
      end
      // retire results before taking new requests
      if (rsp_valid_i && rsp_ready_i) begin
        checks++;
        if (grants_q.size() == 0) begin
          $error("unexpected result transaction: page_address %h status %0d",
                 rsp_data_i, rsp_user_i);
          fails++;
        end else begin
          want = grants_q.pop_front();
          if (rsp_data_i !== want.page_address) begin
            $error("page_address: expected %h, actual %h", want.page_address, rsp_data_i);
            fails++;
          end
          if (rsp_user_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_user_i);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        grants_q.push_back(serve_request(pfa_mode_e'(req_user_i), req_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= grants_q.size();
      checked_o    <= checks;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/page_frame_allocator_test.sv =====
// Top of the page-frame allocator testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on pfa_pkg, the
// allocator RTL and page_frame_allocator_checker.
`default_nettype none

module page_frame_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int unsigned PAGE_SIZE         = 4096;
  localparam int unsigned MAX_PAGES         = 4096;
  localparam int          PAGE_SHIFT        = $clog2(PAGE_SIZE);
  localparam logic [2:0]  REG_RESERVED_BASE = 3'd0;
  localparam logic [2:0]  REG_LIMIT_ADDRESS = 3'd4;
  localparam int          RANDOM_ITEMS      = 1325;
  localparam int          PHASES            = 8;
  localparam int          LONG_HOLD         = 80;
  localparam int          DRAIN_CYCLES      = 10;
  localparam int          TIMEOUT_NS        = 2_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = MODE_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   pending;
  int   checked;
  int   requests_sent = 0;
  int   settings_done = 0;
  int   src_gap_pct   = 10;
  logic quiet_tail    = 1'b0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;
  int   sink_stall_left = 0;
  int   sink_stall_pct  = 0;
  int   sink_window     = 0;

  always #2 clk_i = ~clk_i;

  page_frame_allocator #(
    .PAGE_SIZE (PAGE_SIZE),
    .MAX_PAGES (MAX_PAGES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  page_frame_allocator_checker #(
    .PAGE_SIZE  (PAGE_SIZE),
    .MAX_PAGES  (MAX_PAGES),
    .BASE_ADDR  (REG_RESERVED_BASE),
    .LIMIT_ADDR (REG_LIMIT_ADDRESS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .rsp_user_i   (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Result sink: windows of differing stall density, one long hold-off on request.
  always @(posedge clk_i) begin
    if (sink_window == 0) begin
      sink_window = 150;
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 10;
        default: sink_stall_pct = 35;
      endcase
    end
    sink_window--;
    if (quiet_tail) sink_stall_pct = 0;
    if (sink_stall_left != 0) begin
      sink_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      sink_stall_left = LONG_HOLD - 1;
      hold_off_done   = 1'b1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(1, 100) <= sink_stall_pct) begin
      sink_stall_left = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_request(input pfa_mode_e mode, input logic [31:0] addr);
    if (!quiet_tail && $urandom_range(1, 100) <= src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Back-to-back transfers keep psel high; the caller closes the bus.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] limit);
    wait_drained();
    write_reg(REG_LIMIT_ADDRESS, limit);
    write_reg(REG_RESERVED_BASE, base);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_done++;
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [31:0] limit,
                           input int count, input int pause_at);
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0]     addr;
    int              pick;
    lo = (longint'(base) + PAGE_SIZE - 1) / PAGE_SIZE;
    hi = (longint'(limit) + PAGE_SIZE - 1) / PAGE_SIZE;
    if (hi > MAX_PAGES) hi = MAX_PAGES;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drained();
      // aligned page inside the window, so most frees land on the list
      if (lo < hi) addr = $urandom_range(32'(lo), 32'(hi - 1)) << PAGE_SHIFT;
      else         addr = $urandom & ~(PAGE_SIZE - 1);
      pick = $urandom_range(0, 99);
      if (pick < 50)      push_request(MODE_ALLOC, $urandom);
      else if (pick < 85) push_request(MODE_FREE, addr);
      else if (pick < 93) push_request(MODE_FREE, $urandom);
      else                push_request(MODE_FREE, addr | $urandom_range(1, PAGE_SIZE - 1));
    end
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] base;
    logic [31:0] limit;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window is empty: nothing to allocate, nothing to free
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_FREE,  32'h0000_0000);

    configure(32'h0000_1000, 32'h0000_3000);
    push_request(MODE_ALLOC, 32'hFFFF_FFFF);
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_FREE,  32'h0000_1000);
    push_request(MODE_FREE,  32'h0000_1000);  // double free goes on the list again
    push_request(MODE_FREE,  32'h0000_2000);
    push_request(MODE_FREE,  32'h0000_1800);  // unaligned
    push_request(MODE_FREE,  32'h0000_0000);  // below base
    push_request(MODE_FREE,  32'h0000_3000);  // at limit
    push_request(MODE_FREE,  32'hFFFF_FFFF);
    repeat (4) push_request(MODE_ALLOC, 32'h0000_0000);

    // bump pointer saturates; top pages lie past the link store
    configure(32'hFFFF_E000, 32'hFFFF_FFFF);
    repeat (3) push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_FREE, 32'hFFFF_F000);

    // unaligned base: bump hands out unaligned pages, frees stay aligned
    configure(32'h0000_0800, 32'h0000_2000);
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_FREE,  32'h0000_1000);
    push_request(MODE_ALLOC, 32'h0000_0000);
    push_request(MODE_ALLOC, 32'h0000_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          base  = 32'h0001_0000;
          limit = base + 16 * PAGE_SIZE;
        end
        1: begin
          base  = 32'h0000_0000;
          limit = 32'hFFFF_FFFF;
        end
        2: begin
          base  = 32'h0000_0800;
          limit = 32'h0002_0000;
        end
        3: begin
          base  = $urandom_range(0, 4000) * PAGE_SIZE;
          limit = base + $urandom_range(1, 40) * PAGE_SIZE;
        end
        4: begin
          base  = 32'hFFFF_0000;
          limit = 32'hFFFF_FFFF;
        end
        5: begin
          base  = 32'h0000_8000;
          limit = 32'h0000_4000;
        end
        6: begin
          base  = 32'h00FF_8000;
          limit = 32'h0100_8000;
        end
        default: begin
          base  = $urandom_range(0, 3000) * PAGE_SIZE;
          limit = base + $urandom_range(8, 200) * PAGE_SIZE;
        end
      endcase
      configure(base, limit);
      case (ph % 3)
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 12;
        default: src_gap_pct = 30;
      endcase
      if (ph == 0) hold_off_req <= 1'b1;
      if (ph == PHASES - 1) quiet_tail <= 1'b1;
      run_phase(base, limit, RANDOM_ITEMS / PHASES, (ph == 3) ? RANDOM_ITEMS / PHASES / 2 : -1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests and %0d result transactions over %0d window settings,",
             requests_sent, checked, settings_done);
    $display("including list reuse, double frees, out-of-memory and rejected frees");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
